// ===== hw/rtl/tsl_pkg.sv =====
// package for the task ready and delay sorted lists
// holds sizes, field widths, action codes and the sequencer state type
// no dependencies
`default_nettype none

package tsl_pkg;

    // list depth and derived index widths
    localparam int TASK_SLOTS = 16;
    localparam int IDX_W      = $clog2(TASK_SLOTS);
    localparam int LEN_W      = 5;

    // field widths
    localparam int ACT_W  = 2;
    localparam int ID_W   = 4;
    localparam int PRIO_W = 8;
    localparam int KEY_W  = 32;

    // packed stream word widths
    localparam int IN_W  = 48;
    localparam int OUT_W = 56;
    localparam int OUT_USED_W = 2 * ID_W + KEY_W + 2 + 2 * LEN_W;

    // actions
    typedef enum logic [ACT_W-1:0] {
        ACT_INS_RDY = 2'd0,
        ACT_INS_DLY = 2'd1,
        ACT_RMV_RDY = 2'd2,
        ACT_RMV_DLY = 2'd3
    } t_action;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_FIND,
        ST_SHIFT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/task_ready_and_delay_sorted_lists.sv =====
// top level of the task ready and delay sorted lists, one sequencer; uses tsl_pkg
// sequence: accept in idle, removal scan of the selected list, position search from the head,
// shift from the tail and write of the new entry, then load of the result word; removal only
// or a full list skips search and shift; a held result word delays the load until it is taken
// a new word is taken only in idle, after the result of the last one is loaded; the steps
// run one after another on the single read port shared by scan, search and shift
// reset: synchronous active low, both lists empty, no result pending
`default_nettype none

module task_ready_and_delay_sorted_lists (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input stream
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: task_id, priority_req, delay_ms, run_blocked, pend_blocked, zero fill
    input  wire logic [tsl_pkg::IN_W-1:0] i_s_tdata,
    // tuser: action
    input  wire logic [tsl_pkg::ACT_W-1:0] i_s_tuser,
    // output stream
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    // tdata: ready_head_id, ready_head_valid, ready_count, delay_head_id,
    // delay_head_ms, delay_head_valid, delay_count, zero fill
    output logic [tsl_pkg::OUT_W-1:0]     o_m_tdata
);

    localparam int IDX_W  = tsl_pkg::IDX_W;
    localparam int LEN_W  = tsl_pkg::LEN_W;
    localparam int ID_W   = tsl_pkg::ID_W;
    localparam int PRIO_W = tsl_pkg::PRIO_W;
    localparam int KEY_W  = tsl_pkg::KEY_W;
    localparam int SLOTS  = tsl_pkg::TASK_SLOTS;

    // list storage, no reset: entries at or past the length are never read
    logic [ID_W-1:0]   r_rdy_id  [SLOTS];
    logic [PRIO_W-1:0] r_rdy_key [SLOTS];
    logic [ID_W-1:0]   r_dly_id  [SLOTS];
    logic [KEY_W-1:0]  r_dly_key [SLOTS];

    // control and working registers
    tsl_pkg::t_state    r_state, n_state;
    logic [LEN_W-1:0]   r_rdy_len, n_rdy_len;
    logic [LEN_W-1:0]   r_dly_len, n_dly_len;
    logic               r_sel, n_sel;       // high selects the delay list
    logic               r_ins, n_ins;       // placement follows the removal
    logic [ID_W-1:0]    r_id, n_id;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [LEN_W-1:0]   r_ptr, n_ptr;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_pos, n_pos;
    logic [KEY_W-1:0]   r_prev, n_prev;
    logic               r_found, n_found;
    logic               r_out_valid, n_out_valid;
    logic [tsl_pkg::OUT_W-1:0] r_out_data, n_out_data;

    // datapath signals
    tsl_pkg::t_action   in_action;
    logic               in_blocked;
    logic [IDX_W-1:0]   rd_idx;
    logic [ID_W-1:0]    rd_id;
    logic [KEY_W-1:0]   rd_key;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [ID_W-1:0]    wr_id;
    logic [KEY_W-1:0]   wr_key;
    logic [LEN_W-1:0]   ptr_m1;
    logic [LEN_W-1:0]   drop_len;
    logic               beats_head;
    logic               fits_gap;
    logic [ID_W-1:0]    rdy_head_id;
    logic               rdy_head_valid;
    logic [ID_W-1:0]    dly_head_id;
    logic [KEY_W-1:0]   dly_head_ms;
    logic               dly_head_valid;

    // input word fields
    assign in_action  = tsl_pkg::t_action'(i_s_tuser);
    assign in_blocked = i_s_tdata[44] | i_s_tdata[45];

    // shared read port of the selected list
    assign rd_id  = r_sel ? r_dly_id[rd_idx] : r_rdy_id[rd_idx];
    assign rd_key = r_sel ? r_dly_key[rd_idx]
                          : {{(KEY_W-PRIO_W){1'b0}}, r_rdy_key[rd_idx]};

    // shared compare unit: new key against the entry read and the previous one
    assign beats_head = r_sel ? (r_key < rd_key) : (r_key > rd_key);
    assign fits_gap   = r_sel ? ((r_key >= r_prev) && (r_key <= rd_key))
                              : ((r_key <= r_prev) && (r_key >= rd_key));

    assign ptr_m1   = r_ptr - 1'b1;
    assign drop_len = r_found ? (r_len - 1'b1) : r_len;

    // list heads for the result word
    assign rdy_head_valid = (r_rdy_len != '0);
    assign dly_head_valid = (r_dly_len != '0);
    assign rdy_head_id    = rdy_head_valid ? r_rdy_id[0] : '0;
    assign dly_head_id    = dly_head_valid ? r_dly_id[0] : '0;
    assign dly_head_ms    = dly_head_valid ? r_dly_key[0] : '0;

    // sequencer next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_rdy_len   = r_rdy_len;
        n_dly_len   = r_dly_len;
        n_sel       = r_sel;
        n_ins       = r_ins;
        n_id        = r_id;
        n_key       = r_key;
        n_ptr       = r_ptr;
        n_len       = r_len;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        rd_idx      = r_ptr[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_idx      = r_ptr[IDX_W-1:0];
        wr_id       = rd_id;
        wr_key      = rd_key;
        unique case (r_state)
            tsl_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_sel   = (in_action == tsl_pkg::ACT_INS_DLY) ||
                              (in_action == tsl_pkg::ACT_RMV_DLY);
                    n_ins   = ((in_action == tsl_pkg::ACT_INS_RDY) && !in_blocked) ||
                              (in_action == tsl_pkg::ACT_INS_DLY);
                    n_id    = i_s_tdata[3:0];
                    n_key   = n_sel ? i_s_tdata[43:12]
                                    : {{(KEY_W-PRIO_W){1'b0}}, i_s_tdata[11:4]};
                    n_len   = n_sel ? r_dly_len : r_rdy_len;
                    n_ptr   = '0;
                    n_found = 1'b0;
                    n_state = tsl_pkg::ST_DROP;
                end
            end
            // removal scan: after a match every entry moves one place forward
            tsl_pkg::ST_DROP: begin
                if (r_ptr == r_len) begin
                    n_len = drop_len;
                    if (r_sel) begin
                        n_dly_len = drop_len;
                    end else begin
                        n_rdy_len = drop_len;
                    end
                    n_ptr = '0;
                    if (r_ins && (drop_len < LEN_W'(SLOTS))) begin
                        n_state = tsl_pkg::ST_FIND;
                    end else begin
                        n_state = tsl_pkg::ST_DONE;
                    end
                end else begin
                    if (r_found) begin
                        wr_en  = 1'b1;
                        wr_idx = ptr_m1[IDX_W-1:0];
                    end else if (rd_id == r_id) begin
                        n_found = 1'b1;
                    end
                    n_ptr = r_ptr + 1'b1;
                end
            end
            // position search from the head, tail when nothing fits
            tsl_pkg::ST_FIND: begin
                if (r_ptr == r_len) begin
                    n_pos   = r_len;
                    n_state = tsl_pkg::ST_SHIFT;
                end else if ((r_ptr == '0) ? beats_head : fits_gap) begin
                    n_pos   = r_ptr;
                    n_ptr   = r_len;
                    n_state = tsl_pkg::ST_SHIFT;
                end else begin
                    n_prev = rd_key;
                    n_ptr  = r_ptr + 1'b1;
                end
            end
            // open the gap from the tail, then write the new entry
            tsl_pkg::ST_SHIFT: begin
                wr_en = 1'b1;
                if (r_ptr == r_pos) begin
                    wr_id  = r_id;
                    wr_key = r_key;
                    if (r_sel) begin
                        n_dly_len = r_len + 1'b1;
                    end else begin
                        n_rdy_len = r_len + 1'b1;
                    end
                    n_state = tsl_pkg::ST_DONE;
                end else begin
                    rd_idx = ptr_m1[IDX_W-1:0];
                    n_ptr  = ptr_m1;
                end
            end
            tsl_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(tsl_pkg::OUT_W-tsl_pkg::OUT_USED_W){1'b0}},
                                   r_dly_len, dly_head_valid, dly_head_ms, dly_head_id,
                                   r_rdy_len, rdy_head_valid, rdy_head_id};
                    n_state     = tsl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsl_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsl_pkg::ST_IDLE;
            r_rdy_len   <= '0;
            r_dly_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rdy_len   <= n_rdy_len;
            r_dly_len   <= n_dly_len;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_sel      <= n_sel;
        r_ins      <= n_ins;
        r_id       <= n_id;
        r_key      <= n_key;
        r_ptr      <= n_ptr;
        r_len      <= n_len;
        r_pos      <= n_pos;
        r_prev     <= n_prev;
        r_found    <= n_found;
        r_out_data <= n_out_data;
    end

    // list write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_sel) begin
                r_dly_id[wr_idx]  <= wr_id;
                r_dly_key[wr_idx] <= wr_key;
            end else begin
                r_rdy_id[wr_idx]  <= wr_id;
                r_rdy_key[wr_idx] <= wr_key[PRIO_W-1:0];
            end
        end
    end

    assign o_s_tready = (r_state == tsl_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // checks on list bounds and sequencing
    a_rdy_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdy_len <= LEN_W'(SLOTS))
        else $error("ready list longer than its slots");

    a_dly_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dly_len <= LEN_W'(SLOTS))
        else $error("delay list longer than its slots");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("new word taken while an item is in work");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsl_pkg::ST_SHIFT) |-> ((r_ptr >= r_pos) && (r_ptr < LEN_W'(SLOTS))))
        else $error("shift pointer passed the insert position");

    a_drop_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsl_pkg::ST_DROP) |-> (r_ptr <= r_len))
        else $error("removal scan ran past the list end");

endmodule

`default_nettype wire
